// File: rtl/psx2_pkg.sv
// psx2_pkg: word types, register indexes and channel select helper for the
// 2x pixel shuffle stream unit. No dependencies.
`default_nettype none

package psx2_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 16;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] chan_a;
    logic [VAL_W-1:0] chan_b;
    logic [VAL_W-1:0] chan_c;
    logic [VAL_W-1:0] chan_d;
  } psx2_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] out_value;
    logic             from_lower;
    logic             row_end;
    logic             frame_end;
    logic             pair_last;
  } psx2_out_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_ROW_COUNT       = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MAP_UPPER_LEFT  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MAP_UPPER_RIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MAP_LOWER_LEFT  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_MAP_LOWER_RIGHT = 3'd5;

  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;
  localparam logic [1:0] CH_D = 2'd3;

  function automatic logic [VAL_W-1:0] pick(input logic [1:0] sel, input psx2_in_t px);
    logic [VAL_W-1:0] v;
    case (sel)
      CH_A:    v = px.chan_a;
      CH_B:    v = px.chan_b;
      CH_C:    v = px.chan_c;
      CH_D:    v = px.chan_d;
      default: v = px.chan_a;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pixel_shuffle_2x_stream_unit.sv
// pixel_shuffle_2x_stream_unit: top level of the 2x pixel shuffle stream.
// Uses psx2_pkg (word types, register indexes) and psx2_line_buf.
//
//   channel | direction | ports                          | word
//   --------+-----------+--------------------------------+-------------------
//   in      | sink      | in_valid, in_ready, in_data    | psx2_in_t
//   out     | source    | out_valid, out_ready, out_data | psx2_out_t
//   cfg     | sink      | cfg_valid, cfg_ready,          | index + 16b data
//           |           | cfg_index, cfg_data            |
//
// A pixel or a tick in its own phase loads the result register, which gives
// one output word per cycle while out_ready is high; the line store read
// lands with the first. An ignored word gives no output. Reset clears
// positions, phase and result valid/select and loads register defaults;
// line store and result data stay. An output stall holds result and input.
`default_nettype none

module pixel_shuffle_2x_stream_unit #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned ACT_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire psx2_pkg::psx2_in_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output psx2_pkg::psx2_out_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [psx2_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [psx2_pkg::CDAT_W-1:0]  cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned VB    = (ACT_BITS < psx2_pkg::VAL_W) ? ACT_BITS : psx2_pkg::VAL_W;
  localparam int unsigned SW    = 2 * VB;
  localparam int unsigned CNT_W = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [15:0] row_count_r;
  logic [10:0] column_count_r;
  logic [1:0]  map_ul_r, map_ur_r, map_ll_r, map_lr_r;

  logic [AW-1:0] col_pos_r, col_pos_nxt;
  logic [15:0]   row_pos_r, row_pos_nxt;
  logic          replay_r, replay_nxt;

  logic                         pend_valid_r, pend_valid_nxt;
  logic                         sel_r, sel_nxt;
  logic                         lower_r, lower_nxt;
  logic                         row_end_r, row_end_nxt;
  logic                         frame_end_r, frame_end_nxt;
  logic [psx2_pkg::VAL_W-1:0]   ul_r, ul_nxt, ur_r, ur_nxt;

  logic              in_fire, out_fire, productive, is_pixel;
  logic [CNT_W-1:0]  cols_eff;
  logic [15:0]       rows_eff;
  logic              row_last, frame_last;
  logic [SW-1:0]     wr_data, rd_data;
  logic [VB-1:0]     lo_val, hi_val;
  logic [psx2_pkg::VAL_W-1:0] ul_pick, ur_pick, ll_pick, lr_pick;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 16'd360;
      column_count_r <= 11'd640;
      map_ul_r       <= psx2_pkg::CH_A;
      map_ur_r       <= psx2_pkg::CH_B;
      map_ll_r       <= psx2_pkg::CH_C;
      map_lr_r       <= psx2_pkg::CH_D;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psx2_pkg::REG_ROW_COUNT:       row_count_r    <= cfg_data;
        psx2_pkg::REG_COLUMN_COUNT:    column_count_r <= cfg_data[10:0];
        psx2_pkg::REG_MAP_UPPER_LEFT:  map_ul_r       <= cfg_data[1:0];
        psx2_pkg::REG_MAP_UPPER_RIGHT: map_ur_r       <= cfg_data[1:0];
        psx2_pkg::REG_MAP_LOWER_LEFT:  map_ll_r       <= cfg_data[1:0];
        psx2_pkg::REG_MAP_LOWER_RIGHT: map_lr_r       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // position and phase
  always_comb begin
    if (column_count_r == 11'd0) begin
      cols_eff = CNT_W'(1);
    end else if (CNT_W'(column_count_r) > CNT_W'(MAX_WIDTH)) begin
      cols_eff = CNT_W'(MAX_WIDTH);
    end else begin
      cols_eff = CNT_W'(column_count_r);
    end
  end

  assign rows_eff   = (row_count_r == 16'd0) ? 16'd1 : row_count_r;
  assign row_last   = (CNT_W'(col_pos_r) + CNT_W'(1)) >= cols_eff;
  assign frame_last = row_last && (({1'b0, row_pos_r} + 17'd1) >= {1'b0, rows_eff});

  assign in_ready   = !pend_valid_r || (sel_r && out_ready);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign is_pixel   = (in_data.kind == psx2_pkg::KIND_PIXEL);
  assign productive = is_pixel ? !replay_r : replay_r;

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    replay_nxt  = replay_r;
    if (in_fire && productive) begin
      if (row_last) begin
        col_pos_nxt = '0;
        replay_nxt  = !replay_r;
        if (replay_r) begin
          row_pos_nxt = frame_last ? 16'd0 : row_pos_r + 16'd1;
        end
      end else begin
        col_pos_nxt = col_pos_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      replay_r  <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      replay_r  <= replay_nxt;
    end
  end

  // line store
  assign ul_pick = psx2_pkg::pick(map_ul_r, in_data);
  assign ur_pick = psx2_pkg::pick(map_ur_r, in_data);
  assign ll_pick = psx2_pkg::pick(map_ll_r, in_data);
  assign lr_pick = psx2_pkg::pick(map_lr_r, in_data);

  assign lo_val  = ll_pick[VB-1:0];
  assign hi_val  = lr_pick[VB-1:0];
  assign wr_data = {hi_val, lo_val};

  psx2_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (SW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (in_fire && is_pixel && !replay_r),
    .wr_addr (col_pos_r),
    .wr_data (wr_data),
    .rd_en   (in_fire && !is_pixel && replay_r),
    .rd_addr (col_pos_r),
    .rd_data (rd_data)
  );

  // result register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    sel_nxt        = sel_r;
    lower_nxt      = lower_r;
    row_end_nxt    = row_end_r;
    frame_end_nxt  = frame_end_r;
    ul_nxt         = ul_r;
    ur_nxt         = ur_r;
    if (in_fire && productive) begin
      pend_valid_nxt = 1'b1;
      sel_nxt        = 1'b0;
      lower_nxt      = replay_r;
      row_end_nxt    = row_last;
      frame_end_nxt  = replay_r && frame_last;
      ul_nxt         = psx2_pkg::VAL_W'(ul_pick[VB-1:0]);
      ur_nxt         = psx2_pkg::VAL_W'(ur_pick[VB-1:0]);
    end else if (out_fire) begin
      if (sel_r) begin
        pend_valid_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      sel_r        <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      sel_r        <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lower_r     <= lower_nxt;
    row_end_r   <= row_end_nxt;
    frame_end_r <= frame_end_nxt;
    ul_r        <= ul_nxt;
    ur_r        <= ur_nxt;
  end

  always_comb begin
    out_valid = pend_valid_r;
    if (lower_r) begin
      out_data.out_value = sel_r ? psx2_pkg::VAL_W'(rd_data[SW-1:VB])
                                 : psx2_pkg::VAL_W'(rd_data[VB-1:0]);
    end else begin
      out_data.out_value = sel_r ? ur_r : ul_r;
    end
    out_data.from_lower = lower_r;
    out_data.row_end    = sel_r && row_end_r;
    out_data.frame_end  = sel_r && frame_end_r;
    out_data.pair_last  = sel_r;
  end

`ifndef SYNTHESIS
  a_no_take_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && !sel_r |-> !in_ready)
    else $error("input taken while first word of a pair pending");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && productive |=> out_valid && !out_data.pair_last)
    else $error("productive word did not load the result register");

  a_phase_flip: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(replay_r) |-> $past(in_fire && productive && row_last))
    else $error("phase changed without a row end");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.pair_last |=>
      out_valid && out_data.pair_last && (out_data.from_lower == $past(out_data.from_lower)))
    else $error("second word of pair missing or from the wrong row");
`endif

endmodule

`default_nettype wire

// File: rtl/psx2_line_buf.sv
// psx2_line_buf: single-port-write, single-port-read line store for the
// lower output row, registered read. No package dependency.
`default_nettype none

module psx2_line_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for pixel_shuffle_2x_stream_unit, with a random handshake
// driver and monitor plus a cycle-free model of the 2x depth-to-space shuffle and line store.
// Depends on psx2_pkg (word types, register indexes, channel codes) and the unit's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB_DEPTH = 1024;
  localparam int RANDOM_WORDS = 450;
  localparam int CALM_WORDS = 60;
  localparam int GUARD_CYCLES = 4;
  localparam logic [psx2_pkg::CIDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [psx2_pkg::CIDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  psx2_pkg::psx2_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psx2_pkg::psx2_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psx2_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [psx2_pkg::CDAT_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  pixel_shuffle_2x_stream_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [2*psx2_pkg::VAL_W-1:0] lower_pairs [LB_DEPTH];
  logic [10:0] col_at;
  logic [15:0] row_at;
  logic replaying;
  logic [15:0] rows_reg;
  logic [10:0] cols_reg;
  logic [1:0] sel_ul, sel_ur, sel_ll, sel_lr;

  psx2_pkg::psx2_in_t pixel_q[$];
  psx2_pkg::psx2_out_t upscaled_q[$];

  int fails = 0;
  int n_checked = 0;
  int n_ignored = 0;
  int n_accepted = 0;
  int n_writes = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  int row_len;
  int written_len;
  int rand_words;

  function automatic int cols_in_use(logic [10:0] c);
    if (c == 11'd0) return 1;
    if (int'(c) > LB_DEPTH) return LB_DEPTH;
    return int'(c);
  endfunction

  function automatic int rows_in_use(logic [15:0] r);
    return (r == 16'd0) ? 1 : int'(r);
  endfunction

  function automatic logic [psx2_pkg::VAL_W-1:0] chan_sel(logic [1:0] s,
                                                          psx2_pkg::psx2_in_t w);
    case (s)
      psx2_pkg::CH_A: return w.chan_a;
      psx2_pkg::CH_B: return w.chan_b;
      psx2_pkg::CH_C: return w.chan_c;
      default:        return w.chan_d;
    endcase
  endfunction

  function automatic psx2_pkg::psx2_out_t out_word(logic [psx2_pkg::VAL_W-1:0] v, logic lower,
                                                   logic re, logic fe, logic last);
    psx2_pkg::psx2_out_t o;
    o.out_value  = v;
    o.from_lower = lower;
    o.row_end    = re;
    o.frame_end  = fe;
    o.pair_last  = last;
    return o;
  endfunction

  task automatic shuffle_step(psx2_pkg::psx2_in_t w);
    int cols;
    int idx;
    logic row_last;
    logic frame_last;
    logic [2*psx2_pkg::VAL_W-1:0] pair;
    cols = cols_in_use(cols_reg);
    idx = (int'(col_at) < LB_DEPTH) ? int'(col_at) : LB_DEPTH - 1;
    row_last = (int'(col_at) + 1 >= cols);
    if (w.kind == psx2_pkg::KIND_PIXEL && !replaying) begin
      upscaled_q.push_back(out_word(chan_sel(sel_ul, w), 1'b0, 1'b0, 1'b0, 1'b0));
      upscaled_q.push_back(out_word(chan_sel(sel_ur, w), 1'b0, row_last, 1'b0, 1'b1));
      lower_pairs[idx] = {chan_sel(sel_lr, w), chan_sel(sel_ll, w)};
      if (row_last) begin
        col_at = '0;
        replaying = 1'b1;
      end else begin
        col_at = col_at + 11'd1;
      end
    end else if (w.kind == psx2_pkg::KIND_TICK && replaying) begin
      pair = lower_pairs[idx];
      frame_last = row_last && (int'(row_at) + 1 >= rows_in_use(rows_reg));
      upscaled_q.push_back(out_word(pair[psx2_pkg::VAL_W-1:0], 1'b1, 1'b0, 1'b0, 1'b0));
      upscaled_q.push_back(out_word(pair[2*psx2_pkg::VAL_W-1:psx2_pkg::VAL_W], 1'b1,
                                    row_last, frame_last, 1'b1));
      if (row_last) begin
        col_at = '0;
        replaying = 1'b0;
        row_at = frame_last ? 16'd0 : row_at + 16'd1;
      end else begin
        col_at = col_at + 11'd1;
      end
    end else begin
      n_ignored++;
    end
  endtask

  task automatic set_reg(logic [psx2_pkg::CIDX_W-1:0] idx, logic [psx2_pkg::CDAT_W-1:0] data);
    case (idx)
      psx2_pkg::REG_ROW_COUNT:       rows_reg = data;
      psx2_pkg::REG_COLUMN_COUNT:    cols_reg = data[10:0];
      psx2_pkg::REG_MAP_UPPER_LEFT:  sel_ul = data[1:0];
      psx2_pkg::REG_MAP_UPPER_RIGHT: sel_ur = data[1:0];
      psx2_pkg::REG_MAP_LOWER_LEFT:  sel_ll = data[1:0];
      psx2_pkg::REG_MAP_LOWER_RIGHT: sel_lr = data[1:0];
      default: ;
    endcase
  endtask

  task automatic clear_model();
    for (int i = 0; i < LB_DEPTH; i++) lower_pairs[i] = '0;
    col_at = '0;
    row_at = '0;
    replaying = 1'b0;
    rows_reg = 16'd360;
    cols_reg = 11'd640;
    sel_ul = psx2_pkg::CH_A;
    sel_ur = psx2_pkg::CH_B;
    sel_ll = psx2_pkg::CH_C;
    sel_lr = psx2_pkg::CH_D;
    row_len = cols_in_use(cols_reg);
    written_len = 0;
  endtask

  // drive input words; predict on every accepted word
  always @(posedge clk) begin : drive_in
    logic nv;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shuffle_step(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
          end else begin
            nv = 1'b1;
            in_data <= pixel_q.pop_front();
          end
        end
        in_valid <= nv;
      end
    end
  end

  // check output words; stall at random
  always @(posedge clk) begin : watch_out
    psx2_pkg::psx2_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (upscaled_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected output word %p", out_data);
        end else begin
          want = upscaled_q.pop_front();
          n_checked++;
          if (out_data.out_value !== want.out_value || out_data.from_lower !== want.from_lower ||
              out_data.row_end !== want.row_end || out_data.frame_end !== want.frame_end ||
              out_data.pair_last !== want.pair_last) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: exp val %h low %b re %b fe %b last %b,",
                       want.out_value, want.from_lower, want.row_end, want.frame_end,
                       want.pair_last);
              $display("          got val %h low %b re %b fe %b last %b",
                       out_data.out_value, out_data.from_lower,
                       out_data.row_end, out_data.frame_end, out_data.pair_last);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || upscaled_q.size() != 0) @(posedge clk);
    repeat (GUARD_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [psx2_pkg::CIDX_W-1:0] idx,
                           logic [psx2_pkg::CDAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_reg(idx, data);
    n_writes++;
    if (idx == psx2_pkg::REG_COLUMN_COUNT) row_len = cols_in_use(data[10:0]);
  endtask

  task automatic push_word(logic kind, logic [psx2_pkg::VAL_W-1:0] a,
                           logic [psx2_pkg::VAL_W-1:0] b, logic [psx2_pkg::VAL_W-1:0] c,
                           logic [psx2_pkg::VAL_W-1:0] d, bit counted);
    psx2_pkg::psx2_in_t w;
    w.kind = kind;
    w.chan_a = a;
    w.chan_b = b;
    w.chan_c = c;
    w.chan_d = d;
    pixel_q.push_back(w);
    if (counted) rand_words++;
  endtask

  task automatic push_random(logic kind, bit counted);
    push_word(kind, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), counted);
  endtask

  function automatic logic [15:0] pick_rows();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_cols();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       v[10:0] = 11'd0;
      1:       v[10:0] = 11'd2047;
      2:       v[10:0] = 11'd1024;
      3:       v[10:0] = 11'($urandom_range(1025, 2047));
      4:       v[10:0] = 11'($urandom_range(9, 1023));
      default: v[10:0] = 11'($urandom_range(1, 8));
    endcase
    return v;
  endfunction

  // in the replay phase keep the count within entries already written
  task automatic mid_write(bit in_replay, bit shorten);
    logic [15:0] v;
    wait_idle();
    v = 16'($urandom);
    if (shorten || $urandom_range(0, 2) == 0) begin
      v[10:0] = in_replay ? 11'($urandom_range(0, written_len)) : 11'($urandom_range(0, 12));
      write_reg(psx2_pkg::REG_COLUMN_COUNT, v);
    end else begin
      case ($urandom_range(0, 4))
        0:       write_reg(psx2_pkg::REG_ROW_COUNT, v);
        1:       write_reg(psx2_pkg::REG_MAP_UPPER_LEFT, v);
        2:       write_reg(psx2_pkg::REG_MAP_UPPER_RIGHT, v);
        3:       write_reg(psx2_pkg::REG_MAP_LOWER_LEFT, v);
        default: write_reg(psx2_pkg::REG_MAP_LOWER_RIGHT, v);
      endcase
    end
  endtask

  task automatic send_row();
    int k;
    int n_up;
    int j;
    int n_dn;
    n_up = row_len;
    k = 0;
    while (k < n_up) begin
      if ($urandom_range(0, 11) == 0) push_random(psx2_pkg::KIND_TICK, 1'b0);
      push_random(psx2_pkg::KIND_PIXEL, 1'b1);
      k++;
      if (k < n_up && (row_len > 16 ? k >= 2 : $urandom_range(0, 24) == 0)) begin
        mid_write(1'b0, row_len > 16);
        n_up = (k + 1 > row_len) ? k + 1 : row_len;
      end
    end
    if (n_up > written_len) written_len = n_up;
    n_dn = row_len;
    j = 0;
    while (j < n_dn) begin
      if ($urandom_range(0, 11) == 0) push_random(psx2_pkg::KIND_PIXEL, 1'b0);
      push_random(psx2_pkg::KIND_TICK, 1'b1);
      j++;
      if (j < n_dn && $urandom_range(0, 24) == 0) begin
        mid_write(1'b1, 1'b0);
        n_dn = (j + 1 > row_len) ? j + 1 : row_len;
      end
    end
  endtask

  initial begin
    clear_model();
    rand_words = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, channel extremes, tick in upper phase
    push_word(psx2_pkg::KIND_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'h1357, 16'h2468, 16'h9BDF, 16'hACE0, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 1'b0);
    // shrink mid-row to a zero count, pixel in replay phase
    wait_idle();
    write_reg(psx2_pkg::REG_COLUMN_COUNT, 16'd0);
    push_word(psx2_pkg::KIND_PIXEL, 16'h0001, 16'h0080, 16'h8000, 16'h7FFE, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'h4321, 16'h8765, 16'hCBA9, 16'h0FED, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // one-row frames, reversed channel map
    wait_idle();
    write_reg(psx2_pkg::REG_ROW_COUNT, 16'd0);
    write_reg(psx2_pkg::REG_COLUMN_COUNT, 16'd2);
    write_reg(psx2_pkg::REG_MAP_UPPER_LEFT, {14'd0, psx2_pkg::CH_D});
    write_reg(psx2_pkg::REG_MAP_UPPER_RIGHT, {14'd0, psx2_pkg::CH_C});
    write_reg(psx2_pkg::REG_MAP_LOWER_LEFT, {14'd0, psx2_pkg::CH_B});
    write_reg(psx2_pkg::REG_MAP_LOWER_RIGHT, {14'd0, psx2_pkg::CH_A});
    push_word(psx2_pkg::KIND_PIXEL, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'hFFFE, 16'h7FFF, 16'h8001, 16'h0002, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // unused indexes, largest counts, column count above the line store depth
    wait_idle();
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h0000);
    write_reg(psx2_pkg::REG_ROW_COUNT, 16'hFFFF);
    write_reg(psx2_pkg::REG_COLUMN_COUNT, 16'hFFFF);
    write_reg(psx2_pkg::REG_MAP_UPPER_LEFT, {14'h3FFF, psx2_pkg::CH_C});
    write_reg(psx2_pkg::REG_MAP_LOWER_RIGHT, {14'h3FFF, psx2_pkg::CH_C});
    push_word(psx2_pkg::KIND_PIXEL, 16'hDEAD, 16'hBEEF, 16'hCAFE, 16'hF00D, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'h0F1E, 16'h2D3C, 16'h4B5A, 16'h6978, 1'b0);
    push_word(psx2_pkg::KIND_PIXEL, 16'h8796, 16'hA5B4, 16'hC3D2, 16'hE1F0, 1'b0);
    wait_idle();
    write_reg(psx2_pkg::REG_COLUMN_COUNT, 16'd1);
    push_word(psx2_pkg::KIND_PIXEL, 16'h5A5A, 16'hA5A5, 16'h3C3C, 16'hC3C3, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_word(psx2_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    written_len = 4;

    while (rand_words < RANDOM_WORDS) begin
      wait_idle();
      write_reg(psx2_pkg::REG_ROW_COUNT, pick_rows());
      write_reg(psx2_pkg::REG_COLUMN_COUNT, pick_cols());
      write_reg(psx2_pkg::REG_MAP_UPPER_LEFT, 16'($urandom));
      write_reg(psx2_pkg::REG_MAP_UPPER_RIGHT, 16'($urandom));
      write_reg(psx2_pkg::REG_MAP_LOWER_LEFT, 16'($urandom));
      write_reg(psx2_pkg::REG_MAP_LOWER_RIGHT, 16'($urandom));
      repeat ($urandom_range(1, 4)) begin
        if (rand_words < RANDOM_WORDS) send_row();
        if (rand_words > RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      end
    end

    wait_idle();
    repeat (GUARD_CYCLES) @(posedge clk);
    $display("Covered %0d input words (%0d ignored by phase) across %0d register writes,",
             n_accepted, n_ignored, n_writes);
    $display("checking %0d output words with %0d mismatches.", n_checked, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
